// File: sv/assert_macros.svh
// Assertion macros used by the timer core RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PMT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/pmt_pkg.sv
// Types and constants for the prescaled match timer.
// No dependencies; imported by every timer module.
package pmt_pkg;

  localparam int REG_W    = 32;
  localparam int NUM_CH   = 2;
  localparam int ACT_BITS = 3;
  localparam int PIN_BITS = 2;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CTRL   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_STATUS = 2'd3
  } action_t;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_FUNCS = 3'd4;

  // bit positions inside one channel's action field
  localparam int MA_IRQ  = 0;
  localparam int MA_RST  = 1;
  localparam int MA_STOP = 2;

  // pin function codes
  localparam logic [PIN_BITS-1:0] PIN_NONE   = 2'd0;
  localparam logic [PIN_BITS-1:0] PIN_CLEAR  = 2'd1;
  localparam logic [PIN_BITS-1:0] PIN_SET    = 2'd2;
  localparam logic [PIN_BITS-1:0] PIN_TOGGLE = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0]                   prescale_limit;
    logic [NUM_CH-1:0][REG_W-1:0]       match;
    logic [NUM_CH*ACT_BITS-1:0]         match_actions;
    logic [NUM_CH*PIN_BITS-1:0]         pin_functions;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic        enable_request;
    logic        reset_request;
    logic [1:0]  clear_mask;
  } item_t;

  typedef struct packed {
    logic [REG_W-1:0] timer_value;
    logic [REG_W-1:0] prescale_value;
    logic [1:0]       match_flags;
    logic [1:0]       match_pins;
    logic             interrupt_request;
    logic             running;
  } result_t;

endpackage

// File: sv/pmt_cfg_regs.sv
// Configuration register file of the prescaled match timer.
// Depends on pmt_pkg.
module pmt_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_write_en,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmt_pkg::REG_W-1:0]       cfg_data,
  output pmt_pkg::cfg_t                   cfg
);
  import pmt_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      case (cfg_index)
        CFG_PRESCALE:  cfg_nxt.prescale_limit = cfg_data;
        CFG_MATCH0:    cfg_nxt.match[0]       = cfg_data;
        CFG_MATCH1:    cfg_nxt.match[1]       = cfg_data;
        CFG_ACTIONS:   cfg_nxt.match_actions  = cfg_data[NUM_CH*ACT_BITS-1:0];
        CFG_PIN_FUNCS: cfg_nxt.pin_functions  = cfg_data[NUM_CH*PIN_BITS-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/pmt_core.sv
// Counter state and single-pass update of the prescaled match timer.
// Depends on pmt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pmt_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc,
  input  pmt_pkg::item_t    item,
  input  pmt_pkg::cfg_t     cfg,
  output pmt_pkg::result_t  res
);
  import pmt_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_adv;
  logic [REG_W-1:0]       pre_r, pre_nxt;
  logic                   en_r, en_nxt;
  logic                   hold_r, hold_nxt;
  logic [NUM_CH-1:0]      flags_r, flags_nxt;
  logic [NUM_CH-1:0]      pins_r, pins_nxt;
  logic                   running, pre_wrap, wrap_zero;
  logic [CMP_W-1:0]       cnt_ext, adv_ext, cnt_nxt_ext;

  assign running  = en_r & ~hold_r;
  assign pre_wrap = (pre_r >= cfg.prescale_limit);
  assign cnt_ext  = CMP_W'(cnt_r);

  always_comb begin
    wrap_zero = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (cfg.match_actions[ch*ACT_BITS+MA_RST] && (cnt_ext == CMP_W'(cfg.match[ch]))) begin
        wrap_zero = 1'b1;
      end
    end
  end

  assign cnt_adv = wrap_zero ? '0 : cnt_r + 1'b1;
  assign adv_ext = CMP_W'(cnt_adv);

  always_comb begin
    cnt_nxt   = cnt_r;
    pre_nxt   = pre_r;
    en_nxt    = en_r;
    hold_nxt  = hold_r;
    flags_nxt = flags_r;
    pins_nxt  = pins_r;
    if (proc) begin
      case (item.action)
        ACT_TICK: begin
          if (running) begin
            if (pre_wrap) begin
              pre_nxt = '0;
              cnt_nxt = cnt_adv;
              for (int ch = 0; ch < NUM_CH; ch++) begin
                if (adv_ext == CMP_W'(cfg.match[ch])) begin
                  if (cfg.match_actions[ch*ACT_BITS+MA_IRQ]) flags_nxt[ch] = 1'b1;
                  if (cfg.match_actions[ch*ACT_BITS+MA_STOP]) en_nxt = 1'b0;
                  case (cfg.pin_functions[ch*PIN_BITS +: PIN_BITS])
                    PIN_CLEAR:  pins_nxt[ch] = 1'b0;
                    PIN_SET:    pins_nxt[ch] = 1'b1;
                    PIN_TOGGLE: pins_nxt[ch] = ~pins_r[ch];
                    default:    pins_nxt[ch] = pins_r[ch];
                  endcase
                end
              end
            end else begin
              pre_nxt = pre_r + 1'b1;
            end
          end
        end
        ACT_CTRL: begin
          en_nxt   = item.enable_request;
          hold_nxt = item.reset_request;
          if (item.reset_request) begin
            cnt_nxt = '0;
            pre_nxt = '0;
          end
        end
        ACT_CLEAR: begin
          flags_nxt = flags_r & ~item.clear_mask;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      pre_r   <= '0;
      en_r    <= 1'b0;
      hold_r  <= 1'b0;
      flags_r <= '0;
      pins_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      pre_r   <= pre_nxt;
      en_r    <= en_nxt;
      hold_r  <= hold_nxt;
      flags_r <= flags_nxt;
      pins_r  <= pins_nxt;
    end
  end

  assign cnt_nxt_ext = CMP_W'(cnt_nxt);

  always_comb begin
    res.timer_value       = cnt_nxt_ext[REG_W-1:0];
    res.prescale_value    = pre_nxt;
    res.match_flags       = flags_nxt;
    res.match_pins        = pins_nxt;
    res.interrupt_request = |flags_nxt;
    res.running           = en_nxt & ~hold_nxt;
  end

  `PMT_ASSERT_IMPL(a_hold_zero, clk, rst_n, hold_r, (cnt_r == '0) && (pre_r == '0))
  `PMT_ASSERT_NEXT(a_idle_stable, clk, rst_n, !proc, $stable(cnt_r) && $stable(pre_r) && $stable(flags_r) && $stable(pins_r) && $stable(en_r))
  `PMT_ASSERT_NEXT(a_status_stable, clk, rst_n, proc && (item.action == ACT_STATUS), $stable(cnt_r) && $stable(pre_r) && $stable(flags_r) && $stable(pins_r) && $stable(hold_r))
  `PMT_ASSERT_NEXT(a_flag_source, clk, rst_n, proc && (item.action != ACT_TICK), (flags_r & ~$past(flags_r)) == '0)

endmodule

// File: sv/prescaled_match_timer.sv
// Prescaled match timer: an accepted item goes to the input register, then to the
// result register, which raises out_valid. Throughput one item per cycle while
// out_ready does not stall; the counter update is one combinational pass.
// rst_n is synchronous active low: counters, flags, pins, enable, hold and
// all config registers clear to zero; both pipeline registers empty.
// Depends on pmt_pkg, pmt_cfg_regs, pmt_core.
module prescaled_match_timer #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic                           in_enable_request,
  input  logic                           in_reset_request,
  input  logic [1:0]                     in_clear_mask,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_timer_value,
  output logic [31:0]                    out_prescale_value,
  output logic [1:0]                     out_match_flags,
  output logic [1:0]                     out_match_pins,
  output logic                           out_interrupt_request,
  output logic                           out_running,
  input  logic                           cfg_write_en,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmt_pkg::REG_W-1:0]      cfg_data
);
  import pmt_pkg::*;

  cfg_t    cfg;
  item_t   s1_item_r, s1_item_nxt;
  logic    s1_valid_r, s1_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt, core_res;
  logic    accept, adv;

  assign adv      = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | adv;
  assign accept   = in_valid & in_ready;

  always_comb begin
    s1_item_nxt = s1_item_r;
    if (accept) begin
      s1_item_nxt.action         = action_t'(in_action);
      s1_item_nxt.enable_request = in_enable_request;
      s1_item_nxt.reset_request  = in_reset_request;
      s1_item_nxt.clear_mask     = in_clear_mask;
    end
    s1_valid_nxt  = accept | (s1_valid_r & ~adv);
    out_valid_nxt = adv | (out_valid_r & ~out_ready);
    out_res_nxt   = adv ? core_res : out_res_r;
  end

  pmt_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  pmt_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .proc  (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_timer_value       = out_res_r.timer_value;
  assign out_prescale_value    = out_res_r.prescale_value;
  assign out_match_flags       = out_res_r.match_flags;
  assign out_match_pins        = out_res_r.match_pins;
  assign out_interrupt_request = out_res_r.interrupt_request;
  assign out_running           = out_res_r.running;

endmodule

// File: tb/prescaled_match_timer_test.sv
`timescale 1ns / 100ps
// Testbench for prescaled_match_timer: predicts every result item from its own timer model.
// Drives valid/ready traffic with bursts, stalls and a long output hold-off; needs pmt_pkg.
module prescaled_match_timer_test;
  import pmt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF   = 300;
  localparam int ACTS_W     = NUM_CH * ACT_BITS;
  localparam int PFN_W      = NUM_CH * PIN_BITS;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_action = '0;
  logic                 in_enable_request = 1'b0;
  logic                 in_reset_request = 1'b0;
  logic [1:0]           in_clear_mask = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          out_timer_value;
  logic [31:0]          out_prescale_value;
  logic [1:0]           out_match_flags;
  logic [1:0]           out_match_pins;
  logic                 out_interrupt_request;
  logic                 out_running;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  prescaled_match_timer i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_action             (in_action),
    .in_enable_request     (in_enable_request),
    .in_reset_request      (in_reset_request),
    .in_clear_mask         (in_clear_mask),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_timer_value       (out_timer_value),
    .out_prescale_value    (out_prescale_value),
    .out_match_flags       (out_match_flags),
    .out_match_pins        (out_match_pins),
    .out_interrupt_request (out_interrupt_request),
    .out_running           (out_running),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // timer model state
  cfg_t              timer_cfg = '0;
  logic [REG_W-1:0]  tmr_count = '0;
  logic [REG_W-1:0]  psc_count = '0;
  logic              cnt_enable = 1'b0;
  logic              held = 1'b0;
  logic [NUM_CH-1:0] flags = '0;
  logic [NUM_CH-1:0] pins = '0;

  result_t status_due[$];
  int      fail_count = 0;
  int      idle_cycles = 0;
  int      gap_max = 0;
  int      burst_left = 0;
  int      stall_pct = 0;
  int      hold_off_left = 0;

  function automatic result_t timer_after_item(input item_t it);
    result_t r;
    logic    wrap;
    case (it.action)
      ACT_TICK: begin
        if (cnt_enable && !held) begin
          if (psc_count >= timer_cfg.prescale_limit) begin
            psc_count = '0;
            wrap = 1'b0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
              if (timer_cfg.match_actions[ch*ACT_BITS+MA_RST] && tmr_count == timer_cfg.match[ch])
                wrap = 1'b1;
            end
            tmr_count = wrap ? '0 : tmr_count + 1'b1;
            for (int ch = 0; ch < NUM_CH; ch++) begin
              if (tmr_count == timer_cfg.match[ch]) begin
                if (timer_cfg.match_actions[ch*ACT_BITS+MA_IRQ]) flags[ch] = 1'b1;
                if (timer_cfg.match_actions[ch*ACT_BITS+MA_STOP]) cnt_enable = 1'b0;
                case (timer_cfg.pin_functions[ch*PIN_BITS +: PIN_BITS])
                  PIN_CLEAR: pins[ch] = 1'b0;
                  PIN_SET: pins[ch] = 1'b1;
                  PIN_TOGGLE: pins[ch] = ~pins[ch];
                  default: ;
                endcase
              end
            end
          end else begin
            psc_count = psc_count + 1'b1;
          end
        end
      end
      ACT_CTRL: begin
        cnt_enable = it.enable_request;
        held = it.reset_request;
        if (held) begin
          tmr_count = '0;
          psc_count = '0;
        end
      end
      ACT_CLEAR: flags = flags & ~it.clear_mask;
      default: ;
    endcase
    r.timer_value = tmr_count;
    r.prescale_value = psc_count;
    r.match_flags = flags;
    r.match_pins = pins;
    r.interrupt_request = |flags;
    r.running = cnt_enable && !held;
    return r;
  endfunction

  function automatic cfg_t make_cfg(input logic [REG_W-1:0] psc, m0, m1,
                                    input logic [NUM_CH*ACT_BITS-1:0] acts,
                                    input logic [NUM_CH*PIN_BITS-1:0] pfn);
    cfg_t c;
    c.prescale_limit = psc;
    c.match[0] = m0;
    c.match[1] = m1;
    c.match_actions = acts;
    c.pin_functions = pfn;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    logic [REG_W-1:0]           psc, m0, m1;
    logic [NUM_CH*ACT_BITS-1:0] acts;
    logic [NUM_CH*PIN_BITS-1:0] pfn;
    psc = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
    m0 = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 24);
    m1 = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 24);
    acts = ACTS_W'($urandom);
    pfn = PFN_W'($urandom);
    return make_cfg(psc, m0, m1, acts, pfn);
  endfunction

  // all five registers, upper garbage on the narrow ones, plus one unused index
  task automatic program_timer(input cfg_t c);
    logic [REG_W-1:0]     words[6];
    logic [CFG_IDX_W-1:0] idx[6];
    idx[0] = CFG_PRESCALE;
    words[0] = c.prescale_limit;
    idx[1] = CFG_MATCH0;
    words[1] = c.match[0];
    idx[2] = CFG_MATCH1;
    words[2] = c.match[1];
    idx[3] = CFG_ACTIONS;
    words[3] = $urandom;
    words[3][NUM_CH*ACT_BITS-1:0] = c.match_actions;
    idx[4] = CFG_PIN_FUNCS;
    words[4] = $urandom;
    words[4][NUM_CH*PIN_BITS-1:0] = c.pin_functions;
    idx[5] = CFG_IDX_W'(CFG_PIN_FUNCS + $urandom_range(1, 3));
    words[5] = $urandom;
    for (int i = 0; i < 6; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= words[i];
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
    timer_cfg = c;
  endtask

  task automatic send_item(input action_t a, input logic en, input logic rst,
                           input logic [1:0] mask);
    item_t it;
    int    gap;
    it.action = a;
    it.enable_request = en;
    it.reset_request = rst;
    it.clear_mask = mask;
    if (gap_max > 0 && burst_left == 0) begin
      gap = $urandom_range(1, gap_max);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_action <= a;
    in_enable_request <= en;
    in_reset_request <= rst;
    in_clear_mask <= mask;
    do @(posedge clk); while (!in_ready);
    status_due.push_back(timer_after_item(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly ticks with enabling control writes; the rest clears, reads and noise
  task automatic run_random(input int n);
    action_t     a;
    logic        en, rst;
    logic [1:0]  mask;
    int          pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      en = 1'($urandom);
      rst = 1'($urandom);
      mask = 2'($urandom);
      if (pick < 70) begin
        a = ACT_TICK;
      end else if (pick < 82) begin
        a = ACT_CTRL;
        if ($urandom_range(0, 3) != 0) begin
          en = 1'b1;
          rst = 1'b0;
        end
      end else if (pick < 92) begin
        a = ACT_CLEAR;
      end else begin
        a = ACT_STATUS;
      end
      send_item(a, en, rst, mask);
    end
  endtask

  task automatic test_reset_values();
    send_item(ACT_STATUS, 1'b1, 1'b1, 2'b11);
    send_item(ACT_CLEAR, 1'b1, 1'b1, 2'b11);
  endtask

  task automatic test_hold_reset();
    send_item(ACT_CTRL, 1'b1, 1'b1, 2'b00);
    send_item(ACT_TICK, 1'b0, 1'b0, 2'b00);
    send_item(ACT_CTRL, 1'b1, 1'b0, 2'b00);
    send_item(ACT_TICK, 1'b0, 1'b0, 2'b00);
  endtask

  // channel 0 resets the count at 2 and toggles its pin, channel 1 fires on the wrap to 0
  task automatic test_match_events();
    drain();
    program_timer(make_cfg(1, 2, 0,
                           ACTS_W'((1 << MA_IRQ) | (1 << MA_RST) | (1 << (ACT_BITS + MA_IRQ))),
                           {PIN_SET, PIN_TOGGLE}));
    send_item(ACT_CTRL, 1'b1, 1'b1, 2'b00);
    send_item(ACT_CTRL, 1'b1, 1'b0, 2'b00);
    repeat (6) send_item(ACT_TICK, 1'b0, 1'b0, 2'b00);
    send_item(ACT_CLEAR, 1'b0, 1'b0, 2'b01);
    send_item(ACT_CLEAR, 1'b0, 1'b0, 2'b10);
  endtask

  task automatic test_match_stop();
    drain();
    program_timer(make_cfg(0, '1, 1,
                           ACTS_W'((1 << (ACT_BITS + MA_IRQ)) | (1 << (ACT_BITS + MA_STOP))),
                           {PIN_TOGGLE, PIN_CLEAR}));
    send_item(ACT_CTRL, 1'b1, 1'b1, 2'b00);
    send_item(ACT_CTRL, 1'b1, 1'b0, 2'b00);
    repeat (3) send_item(ACT_TICK, 1'b0, 1'b0, 2'b00);
    send_item(ACT_STATUS, 1'b0, 1'b0, 2'b00);
  endtask

  task automatic test_prescale_lowered();
    drain();
    program_timer(make_cfg('1, '0, '0, '0, '0));
    send_item(ACT_CTRL, 1'b1, 1'b0, 2'b00);
    repeat (3) send_item(ACT_TICK, 1'b0, 1'b0, 2'b00);
    drain();
    program_timer(make_cfg(1, '0, '0, '0, '0));
    send_item(ACT_TICK, 1'b0, 1'b0, 2'b00);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          program_timer(make_cfg('0, '0, '0, '0, '0));
          gap_max = 0;
          stall_pct = 0;
        end
        1: begin
          program_timer(make_cfg('1, '1, '1, '1, '1));
          gap_max = 6;
          stall_pct = 30;
        end
        default: begin
          program_timer(random_cfg());
          gap_max = $urandom_range(0, 8);
          stall_pct = 25 * $urandom_range(0, 3);
        end
      endcase
      run_random(110);
    end
  endtask

  task automatic test_backpressure();
    drain();
    program_timer(random_cfg());
    gap_max = 0;
    stall_pct = 0;
    hold_off_left = HOLD_OFF;
    run_random(60);
  endtask

  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [REG_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        want = status_due.pop_front();
        check_field("timer_value", want.timer_value, out_timer_value);
        check_field("prescale_value", want.prescale_value, out_prescale_value);
        check_field("match_flags", REG_W'(want.match_flags), REG_W'(out_match_flags));
        check_field("match_pins", REG_W'(want.match_pins), REG_W'(out_match_pins));
        check_field("interrupt_request", REG_W'(want.interrupt_request),
                    REG_W'(out_interrupt_request));
        check_field("running", REG_W'(want.running), REG_W'(out_running));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_hold_reset();
    test_match_events();
    test_match_stop();
    test_prescale_lowered();
    test_random_traffic();
    test_backpressure();
    drain();
    if (fail_count == 0 && status_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/pmt_pkg.sv
sv/pmt_cfg_regs.sv
sv/pmt_core.sv
sv/prescaled_match_timer.sv
tb/prescaled_match_timer_test.sv
